>>> hw/rtl/agps_pkg.sv
package agps_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int COST_BITS = 24;
  localparam int CNT_W     = 7;
  localparam int EDGE_AW   = 2 * NODE_W;

  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [1:0]           cmd_t;

  localparam cost_t INFINITY = {COST_BITS{1'b1}};

  localparam cmd_t CMD_SET_NODE = 2'd0;
  localparam cmd_t CMD_SET_EDGE = 2'd1;
  localparam cmd_t CMD_CLEAR    = 2'd2;
  localparam cmd_t CMD_SEARCH   = 2'd3;

  // saturating cost add
  function automatic cost_t sat_add(cost_t a, cost_t b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_BITS] ? INFINITY : s[COST_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/agps_in_if.sv
interface agps_in_if;
  import agps_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  node_t node_a;
  node_t node_b;
  cost_t value;
  logic  is_end;
  modport source (output valid, cmd, node_a, node_b, value, is_end, input ready);
  modport sink   (input valid, cmd, node_a, node_b, value, is_end, output ready);
endinterface

>>> hw/rtl/agps_out_if.sv
interface agps_out_if;
  import agps_pkg::*;
  logic  valid;
  logic  ready;
  logic  found;
  node_t path_node;
  cost_t path_cost;
  logic  last;
  modport source (output valid, found, path_node, path_cost, last, input ready);
  modport sink   (input valid, found, path_node, path_cost, last, output ready);
endinterface

>>> hw/rtl/astar_graph_path_search.sv
// A* path search engine. Load commands are taken while idle; clear graph resets every
// edge and goal flag. Search: an init sweep of the cost memory, then per expansion an
// edge-row relax scan plus an open-set selection scan, one node per cycle through the
// cost memory; the expansion that picks a goal skips both scans; up to 256 expansions.
// The path walk stacks the prev chain, then items are emitted. One item in flight at a
// time. Reset (rst_n low, synchronous) runs an edge and goal clearing pass first.
module astar_graph_path_search (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [agps_pkg::CNT_W-1:0] cfg_wdata,
  agps_in_if.sink                  in_item,
  agps_out_if.source               out_item
);
  import agps_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_EXP   = 4'd3;
  localparam logic [3:0] S_EXPW  = 4'd4;
  localparam logic [3:0] S_RELAX = 4'd5;
  localparam logic [3:0] S_SEL   = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_WALKW = 4'd8;
  localparam logic [3:0] S_EMRD  = 4'd9;
  localparam logic [3:0] S_EMRD2 = 4'd10;
  localparam logic [3:0] S_EMCST = 4'd11;
  localparam logic [3:0] S_EMOUT = 4'd12;
  localparam logic [3:0] S_FAIL  = 4'd13;

  localparam logic [NODE_W:0] NODE_NONE = (NODE_W+1)'(MAX_NODES);
  localparam logic [8:0] EXPAND_LIMIT = 9'(4 * MAX_NODES);

  logic [3:0] state_r, state_nxt;

  logic [CNT_W-1:0]   node_count_r;
  logic [EDGE_AW-1:0] clr_r;
  logic [MAX_NODES-1:0] hvalid_r;
  node_t start_r, cur_r, pick_r, idx_r, s1_idx_r, ptr_r, node_r;
  logic [NODE_W:0] init_r, n_r, len_r;
  logic [8:0] iter_r;
  logic iss_r, s1_v_r, any_r, pick_v_r;
  cost_t cur_cost_r, least_r, cost_r;

  logic out_valid_r, out_found_r, out_last_r;
  node_t out_node_r;
  cost_t out_cost_r;

  // memory ports; the cost memory carries the open flag in its top bit
  logic edge_we, heur_we, best_we, prev_we, stack_we, goal_we;
  logic [EDGE_AW-1:0] edge_waddr;
  cost_t edge_wdata, edge_rd, heur_rd, best_cost;
  logic [COST_BITS:0] best_wdata, best_rd;
  logic best_open;
  node_t best_waddr, best_raddr, stack_rd, goal_waddr;
  logic [NODE_W:0] prev_wdata, prev_rd;
  logic goal_wdata, goal_rd;

  logic in_acc, out_free, out_load;
  node_t cnt_m1;
  logic [CNT_W-1:0] cnt;
  cost_t nc, f, h;
  logic edge_fin, relax_upd, s1_last, walk_go;

  assign in_item.ready = (state_r == S_IDLE);
  assign in_acc        = in_item.valid && in_item.ready;
  assign out_free      = !out_valid_r || out_item.ready;
  assign out_load      = out_free && (state_r == S_EMOUT || state_r == S_FAIL);

  assign out_item.valid     = out_valid_r;
  assign out_item.found     = out_found_r;
  assign out_item.path_node = out_node_r;
  assign out_item.path_cost = out_cost_r;
  assign out_item.last      = out_last_r;

  // node_count: 0 acts as 1, above MAX_NODES saturates
  always_comb begin
    if (node_count_r == '0) begin
      cnt = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      cnt = CNT_W'(MAX_NODES);
    end else begin
      cnt = node_count_r;
    end
  end
  assign cnt_m1 = NODE_W'(cnt - CNT_W'(1));

  // scan datapath; stage 1 sees the registered memory data for s1_idx_r
  assign best_cost = best_rd[COST_BITS-1:0];
  assign best_open = best_rd[COST_BITS];
  assign s1_last   = s1_v_r && (s1_idx_r == cnt_m1);
  assign edge_fin  = (edge_rd != INFINITY);
  assign nc        = sat_add(cur_cost_r, edge_rd);
  assign relax_upd = (state_r == S_RELAX) && s1_v_r && edge_fin && (best_cost > nc);
  assign h         = hvalid_r[s1_idx_r] ? heur_rd : '0;   // unwritten heuristic reads zero
  assign f         = sat_add(best_cost, h);
  assign walk_go   = !n_r[NODE_W] && !len_r[NODE_W];

  always_comb begin
    edge_we    = (state_r == S_CLR) || (in_acc && in_item.cmd == CMD_SET_EDGE);
    edge_waddr = (state_r == S_CLR) ? clr_r : {in_item.node_a, in_item.node_b};
    edge_wdata = (state_r == S_CLR) ? INFINITY : in_item.value;
    heur_we    = in_acc && (in_item.cmd == CMD_SET_NODE);
    // goal flags are wiped while the clearing pass walks its first MAX_NODES addresses
    goal_we    = ((state_r == S_CLR) && (clr_r[EDGE_AW-1:NODE_W] == '0)) || heur_we;
    goal_waddr = (state_r == S_CLR) ? clr_r[NODE_W-1:0] : in_item.node_a;
    goal_wdata = (state_r == S_CLR) ? 1'b0 : in_item.is_end;
    best_we    = (state_r == S_INIT) || (state_r == S_EXPW) || relax_upd;
    prev_we    = (state_r == S_INIT) || relax_upd;
    if (state_r == S_INIT) begin
      best_waddr = init_r[NODE_W-1:0];
      best_wdata = {1'b0, (init_r[NODE_W-1:0] == start_r) ? cost_t'(0) : INFINITY};
      prev_wdata = NODE_NONE;
    end else if (state_r == S_EXPW) begin
      // close the node being expanded
      best_waddr = cur_r;
      best_wdata = {1'b0, best_cost};
      prev_wdata = {1'b0, cur_r};
    end else begin
      best_waddr = s1_idx_r;
      best_wdata = {1'b1, nc};
      prev_wdata = {1'b0, cur_r};
    end
    unique case (state_r)
      S_EXP:   best_raddr = cur_r;
      S_EMRD2: best_raddr = stack_rd;
      default: best_raddr = idx_r;
    endcase
    stack_we = (state_r == S_WALK) && walk_go;
  end

  agps_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_edge (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr({cur_r, idx_r}), .rdata(edge_rd));

  agps_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_NODES)) u_heur (
    .clk, .we(heur_we), .waddr(in_item.node_a), .wdata(in_item.value),
    .raddr(idx_r), .rdata(heur_rd));

  agps_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_goal (
    .clk, .we(goal_we), .waddr(goal_waddr), .wdata(goal_wdata),
    .raddr(cur_r), .rdata(goal_rd));

  agps_ram #(.WIDTH(COST_BITS + 1), .DEPTH(MAX_NODES)) u_best (
    .clk, .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
    .raddr(best_raddr), .rdata(best_rd));

  agps_ram #(.WIDTH(NODE_W + 1), .DEPTH(MAX_NODES)) u_prev (
    .clk, .we(prev_we), .waddr(best_waddr), .wdata(prev_wdata),
    .raddr(n_r[NODE_W-1:0]), .rdata(prev_rd));

  agps_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack (
    .clk, .we(stack_we), .waddr(len_r[NODE_W-1:0]), .wdata(n_r[NODE_W-1:0]),
    .raddr(ptr_r), .rdata(stack_rd));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.cmd == CMD_CLEAR)       state_nxt = S_CLR;
          else if (in_item.cmd == CMD_SEARCH) state_nxt = S_INIT;
        end
      end
      S_INIT:  if (init_r[NODE_W-1:0] == node_t'(MAX_NODES - 1)) state_nxt = S_EXP;
      S_EXP:   state_nxt = (iter_r == EXPAND_LIMIT) ? S_FAIL : S_EXPW;
      S_EXPW:  state_nxt = goal_rd ? S_WALK : S_RELAX;
      S_RELAX: if (s1_last) state_nxt = (any_r || edge_fin) ? S_SEL : S_FAIL;
      S_SEL: begin
        if (s1_last) begin
          if ((best_open && f < least_r) || pick_v_r) state_nxt = S_EXP;
          else                                        state_nxt = S_FAIL;
        end
      end
      S_WALK:  state_nxt = walk_go ? S_WALKW : S_EMRD;
      S_WALKW: state_nxt = S_WALK;
      S_EMRD:  state_nxt = S_EMRD2;
      S_EMRD2: state_nxt = S_EMCST;
      S_EMCST: state_nxt = S_EMOUT;
      S_EMOUT: if (out_free) state_nxt = (ptr_r == '0) ? S_IDLE : S_EMRD;
      S_FAIL:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      node_count_r <= CNT_W'(MAX_NODES);
      hvalid_r     <= '0;
      out_valid_r  <= 1'b0;
      iss_r        <= 1'b0;
      s1_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) node_count_r <= cfg_wdata;
      if (out_valid_r && out_item.ready && !out_load) out_valid_r <= 1'b0;

      // scan issue: one address a cycle, stage 1 follows in the cycle after
      s1_v_r   <= iss_r;
      s1_idx_r <= idx_r;
      if (iss_r) begin
        if (idx_r == cnt_m1) iss_r <= 1'b0;
        else                 idx_r <= idx_r + node_t'(1);
      end

      unique case (state_r)
        S_CLR: clr_r <= clr_r + EDGE_AW'(1);
        S_IDLE: begin
          clr_r <= '0;
          if (in_acc) begin
            unique case (in_item.cmd)
              CMD_SET_NODE: hvalid_r[in_item.node_a] <= 1'b1;
              CMD_SEARCH: begin
                start_r <= in_item.node_a;
                init_r  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          init_r <= init_r + (NODE_W+1)'(1);
          cur_r  <= start_r;
          iter_r <= '0;
        end
        S_EXP: begin
          n_r   <= {1'b0, cur_r};
          len_r <= '0;
        end
        S_EXPW: begin
          cur_cost_r <= best_cost;
          if (!goal_rd) begin
            any_r <= 1'b0;
            idx_r <= '0;
            iss_r <= 1'b1;
          end
        end
        S_RELAX: begin
          if (s1_v_r && edge_fin) any_r <= 1'b1;
          if (s1_last) begin
            idx_r    <= '0;
            iss_r    <= 1'b1;
            least_r  <= INFINITY;
            pick_v_r <= 1'b0;
          end
        end
        S_SEL: begin
          if (s1_v_r && best_open && f < least_r) begin
            least_r  <= f;
            pick_r   <= s1_idx_r;
            pick_v_r <= 1'b1;
          end
          if (s1_last) begin
            iss_r  <= 1'b0;
            iter_r <= iter_r + 9'd1;
            cur_r  <= (best_open && f < least_r) ? s1_idx_r : pick_r;
          end
        end
        S_WALK: begin
          if (walk_go) len_r <= len_r + (NODE_W+1)'(1);
          else         ptr_r <= NODE_W'(len_r - (NODE_W+1)'(1));
        end
        S_WALKW: n_r <= prev_rd;
        S_EMRD2: node_r <= stack_rd;
        S_EMCST: cost_r <= best_cost;
        S_EMOUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= 1'b1;
            out_node_r  <= node_r;
            out_cost_r  <= cost_r;
            out_last_r  <= (ptr_r == '0);
            ptr_r       <= ptr_r - node_t'(1);
          end
        end
        S_FAIL: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= 1'b0;
            out_node_r  <= '0;
            out_cost_r  <= '0;
            out_last_r  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/agps_ram.sv
module agps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/agps_checker.sv
module agps_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_cmd,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_found,
  input logic [agps_pkg::NODE_W-1:0]    out_path_node,
  input logic [agps_pkg::COST_BITS-1:0] out_path_cost,
  input logic                      out_last
);
  import agps_pkg::*;

  // searches taken whose last item has not yet gone out
  logic [1:0] pend_r;
  logic srch_acc, last_acc;

  assign srch_acc = in_valid && in_ready && (in_cmd == CMD_SEARCH);
  assign last_acc = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (srch_acc && !last_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (!srch_acc && last_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_search_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    srch_acc |=> !in_ready) else $error("input taken right after a search");

  a_result_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0)) else $error("result item outside a search");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3) else $error("too many searches pending");

  a_fail_item_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_last && out_path_node == '0 && out_path_cost == '0))
    else $error("malformed failure item");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_path_node)
                                   && $stable(out_path_cost) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind astar_graph_path_search agps_checker u_agps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .in_cmd        (in_item.cmd),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .out_found     (out_item.found),
  .out_path_node (out_item.path_node),
  .out_path_cost (out_item.path_cost),
  .out_last      (out_item.last)
);
